>>> sv/pahit_pkg.sv
// Shared constants for the padded arrow hit test unit.
// Register indexes, default parameters and the sequencer state codes.
// No dependencies.
package pahit_pkg;

  localparam int unsigned NUM_REGS       = 7;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned POINT_W        = 16;

  localparam int unsigned DEF_PAD        = 4;
  localparam int unsigned DEF_COORD_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PARENT_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARENT_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C     = 3'd6;

  // vertex padding sequencer
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SETUP = 8'b0000_0010,
    ST_SQR   = 8'b0000_0100,
    ST_TGT   = 8'b0000_1000,
    ST_CSQ   = 8'b0001_0000,
    ST_PLO   = 8'b0010_0000,
    ST_CMP   = 8'b0100_0000,
    ST_STORE = 8'b1000_0000
  } seq_state_e;

endpackage

>>> sv/padded_arrow_hit_test_unit.sv
// Padded arrow hit test: window, padded shaft box and padded head triangle.
// Depends on pahit_pkg.
//
// A query point is accepted every cycle while no recompute runs and the
// output is not stalled; it is held in an input register and its result is
// registered in an output register. The input register and the result
// register keep the input side moving while a result waits. Each register
// write starts a recompute of the padded head vertices: six offsets, each
// found by a bit-by-bit search of one shared multiply sequence (setup,
// square, target, then square, product, compare per bit, then store).
// While it runs, neither points nor further register writes are accepted.
module padded_arrow_hit_test_unit #(
  parameter int unsigned PAD        = pahit_pkg::DEF_PAD,
  parameter int unsigned COORD_BITS = pahit_pkg::DEF_COORD_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [pahit_pkg::POINT_W-1:0]   point_x_i,
  input  logic signed [pahit_pkg::POINT_W-1:0]   point_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   hit_o,
  output logic                                   in_box_o,
  output logic                                   in_triangle_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pahit_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pahit_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned CW   = (COORD_BITS > 16) ? 16 : COORD_BITS;
  localparam int unsigned DW   = CW + 3;
  localparam int unsigned AW   = CW + 2;
  localparam int unsigned LW   = 2 * AW;
  localparam int unsigned KVAL = PAD * 256;
  localparam int unsigned KW   = (KVAL == 0) ? 1 : $clog2(KVAL + 1);
  localparam int unsigned BW   = (KW > 1) ? $clog2(KW) : 1;
  localparam int unsigned KAW  = KW + AW;
  localparam int unsigned C2W  = 2 * KW;
  localparam int unsigned PPW  = C2W + AW;
  localparam int unsigned PRW  = C2W + LW;
  localparam int unsigned PW   = CW + 10;
  localparam int unsigned QW   = ((PW > pahit_pkg::POINT_W + 8) ? PW
                                                                : pahit_pkg::POINT_W + 8) + 1;
  localparam int unsigned XW   = 2 * QW;
  localparam int unsigned EW   = pahit_pkg::POINT_W + 2;

  function automatic logic signed [CW-1:0] coord(input logic [31:0] r, input logic hi);
    logic [15:0] h;
    h = hi ? r[31:16] : r[15:0];
    return signed'(h[CW-1:0]);
  endfunction

  // ---------------- configuration registers ----------------
  logic [pahit_pkg::CFG_DATA_W-1:0] cfg_q [pahit_pkg::NUM_REGS];
  pahit_pkg::seq_state_e state_q, state_d;
  logic busy;
  logic cfg_fire;

  assign busy        = (state_q != pahit_pkg::ST_IDLE);
  assign cfg_ready_o = !busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pahit_pkg::NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_fire && (cfg_index_i < pahit_pkg::CFG_IDX_W'(pahit_pkg::NUM_REGS))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // ---------------- vertex padding sequencer ----------------
  logic [1:0]          vtx_q;
  logic                axis_q;
  logic [AW-1:0]       ad_q, ao_q;
  logic                neg_q;
  logic [LW-1:0]       ad2_q, ao2_q, len2_q;
  logic [KAW-1:0]      kad_q;
  logic [PRW-1:0]      tgt_q;
  logic [KW-1:0]       q_q;
  logic [BW-1:0]       bit_q;
  logic [C2W-1:0]      c2_q;
  logic                cok_q;
  logic [PPW-1:0]      plo_q, phi_q;
  logic signed [PW-1:0] pvx_q [3];
  logic signed [PW-1:0] pvy_q [3];

  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [DW-1:0] sum_x, sum_y, d_x, d_y, d_self, d_other;
  logic signed [CW-1:0] v_cur;
  logic [KW-1:0]        cand;
  logic [PRW-1:0]       prod;
  logic signed [PW-1:0] offs, pv_new;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = coord(cfg_q[int'(pahit_pkg::REG_VERTEX_A) + i], 1'b0);
      vy[i] = coord(cfg_q[int'(pahit_pkg::REG_VERTEX_A) + i], 1'b1);
    end
    sum_x = DW'(vx[0]) + DW'(vx[1]) + DW'(vx[2]);
    sum_y = DW'(vy[0]) + DW'(vy[1]) + DW'(vy[2]);
    d_x   = (DW'(vx[vtx_q]) <<< 1) + DW'(vx[vtx_q]) - sum_x;
    d_y   = (DW'(vy[vtx_q]) <<< 1) + DW'(vy[vtx_q]) - sum_y;
    d_self  = axis_q ? d_y : d_x;
    d_other = axis_q ? d_x : d_y;
    v_cur   = axis_q ? vy[vtx_q] : vx[vtx_q];
    cand    = q_q | (KW'(1) << bit_q);
    prod    = PRW'(plo_q) + (PRW'(phi_q) << AW);
    // centroid vertex gets no push
    offs    = (len2_q == '0) ? '0 :
              (neg_q ? -signed'(PW'(q_q)) : signed'(PW'(q_q)));
    pv_new  = (PW'(v_cur) <<< 8) + offs;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pahit_pkg::ST_IDLE:  if (cfg_fire) state_d = pahit_pkg::ST_SETUP;
      pahit_pkg::ST_SETUP: state_d = pahit_pkg::ST_SQR;
      pahit_pkg::ST_SQR:   state_d = pahit_pkg::ST_TGT;
      pahit_pkg::ST_TGT:   state_d = pahit_pkg::ST_CSQ;
      pahit_pkg::ST_CSQ:   state_d = pahit_pkg::ST_PLO;
      pahit_pkg::ST_PLO:   state_d = pahit_pkg::ST_CMP;
      pahit_pkg::ST_CMP:   state_d = (bit_q == '0) ? pahit_pkg::ST_STORE : pahit_pkg::ST_CSQ;
      pahit_pkg::ST_STORE: state_d = (axis_q && vtx_q == 2'd2) ? pahit_pkg::ST_IDLE
                                                               : pahit_pkg::ST_SETUP;
      default:             state_d = pahit_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pahit_pkg::ST_IDLE;
      vtx_q   <= '0;
      axis_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pvx_q[i] <= '0;
        pvy_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        pahit_pkg::ST_IDLE: begin
          vtx_q  <= '0;
          axis_q <= 1'b0;
        end
        pahit_pkg::ST_STORE: begin
          if (axis_q) pvy_q[vtx_q] <= pv_new;
          else        pvx_q[vtx_q] <= pv_new;
          axis_q <= !axis_q;
          if (axis_q) vtx_q <= vtx_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // search datapath, its multiplies registered per sequencer state
  always_ff @(posedge clk_i) begin
    case (state_q)
      pahit_pkg::ST_SETUP: begin
        ad_q  <= d_self[DW-1] ? AW'(-d_self) : AW'(d_self);
        ao_q  <= d_other[DW-1] ? AW'(-d_other) : AW'(d_other);
        neg_q <= d_self[DW-1];
      end
      pahit_pkg::ST_SQR: begin
        ad2_q <= LW'(ad_q) * LW'(ad_q);
        ao2_q <= LW'(ao_q) * LW'(ao_q);
        kad_q <= KAW'(KVAL) * KAW'(ad_q);
      end
      pahit_pkg::ST_TGT: begin
        len2_q <= ad2_q + ao2_q;
        tgt_q  <= PRW'(kad_q) * PRW'(kad_q);
        q_q    <= '0;
        bit_q  <= BW'(KW - 1);
      end
      pahit_pkg::ST_CSQ: begin
        c2_q  <= C2W'(cand) * C2W'(cand);
        cok_q <= (cand <= KW'(KVAL));
      end
      pahit_pkg::ST_PLO: begin
        plo_q <= PPW'(c2_q) * PPW'(len2_q[AW-1:0]);
        phi_q <= PPW'(c2_q) * PPW'(len2_q[LW-1:AW]);
      end
      pahit_pkg::ST_CMP: begin
        if (cok_q && prod <= tgt_q) q_q <= cand;
        bit_q <= bit_q - BW'(1);
      end
      default: ;
    endcase
  end

  // ---------------- query pipeline ----------------
  logic                               ivalid_q, ovalid_q;
  logic signed [pahit_pkg::POINT_W-1:0] px_q, py_q;
  logic                               adv, in_fire;
  logic                               hit_q, box_q, tri_q;

  assign adv        = !ovalid_q || out_ready_i;
  assign in_ready_o = (!ivalid_q || adv) && !busy;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivalid_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (in_fire)  ivalid_q <= 1'b1;
      else if (adv) ivalid_q <= 1'b0;
      if (adv) ovalid_q <= ivalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  logic signed [EW-1:0] ex, ey;
  logic in_win, in_box, in_tri, pos, neg;
  logic signed [QW-1:0] fx, fy, apx, apy, abx, aby;
  logic signed [XW:0]   cr;

  always_comb begin
    ex = EW'(px_q);
    ey = EW'(py_q);
    in_win = !(EW'(coord(cfg_q[pahit_pkg::REG_PARENT_START], 1'b0)) > ex ||
               EW'(coord(cfg_q[pahit_pkg::REG_PARENT_START], 1'b1)) > ey ||
               EW'(coord(cfg_q[pahit_pkg::REG_PARENT_END],   1'b0)) <= ex ||
               EW'(coord(cfg_q[pahit_pkg::REG_PARENT_END],   1'b1)) <= ey);
    in_box = !(ex < EW'(coord(cfg_q[pahit_pkg::REG_BOX_MIN], 1'b0)) - signed'(EW'(PAD)) ||
               ex > EW'(coord(cfg_q[pahit_pkg::REG_BOX_MAX], 1'b0)) + signed'(EW'(PAD)) ||
               ey < EW'(coord(cfg_q[pahit_pkg::REG_BOX_MIN], 1'b1)) - signed'(EW'(PAD)) ||
               ey > EW'(coord(cfg_q[pahit_pkg::REG_BOX_MAX], 1'b1)) + signed'(EW'(PAD)));
    fx  = QW'(px_q) <<< 8;
    fy  = QW'(py_q) <<< 8;
    pos = 1'b0;
    neg = 1'b0;
    apx = '0; apy = '0; abx = '0; aby = '0; cr = '0;
    // one edge cross product per triangle side
    for (int i = 0; i < 3; i++) begin
      apx = fx - QW'(pvx_q[i]);
      apy = fy - QW'(pvy_q[i]);
      abx = QW'(pvx_q[(i + 1) % 3]) - QW'(pvx_q[i]);
      aby = QW'(pvy_q[(i + 1) % 3]) - QW'(pvy_q[i]);
      cr  = (XW + 1)'(apx * aby) - (XW + 1)'(apy * abx);
      if (cr > 0) pos = 1'b1;
      if (cr < 0) neg = 1'b1;
    end
    in_tri = !(pos && neg);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= in_win && (in_box || in_tri);
      box_q <= in_box;
      tri_q <= in_tri;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign hit_o         = hit_q;
  assign in_box_o      = box_q;
  assign in_triangle_o = tri_q;

endmodule
